[rtl/core/insertion_sorter_top_defines.svh]
// ----------------------------------------------------------------------------
// insertion_sorter_top_defines: assertion macros
// Shared assertion wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_TOP_DEFINES_SVH
`define INSERTION_SORTER_TOP_DEFINES_SVH

// check a property only while out of reset
`define INSSORT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define INSSORT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/inssort_pkg.sv]
// ----------------------------------------------------------------------------
// inssort_pkg
// Sizes, payload types and controller/datapath interface for the sorter.
// ----------------------------------------------------------------------------
package inssort_pkg;

    localparam int MAX_ITEMS  = 32;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  final_item;
    } t_in_item;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] sorted_value;
        logic                  last_result;
        logic                  overflow;
    } t_result;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_dp_cmd;

    typedef struct packed {
        logic one_left;
    } t_dp_stat;

endpackage

[rtl/core/inssort_dp.sv]
// ----------------------------------------------------------------------------
// inssort_dp
// Chain of compare-and-shift cells: inserts one value per cycle in stable
// ascending order (dropping and flagging it once full), and shifts the set out toward cell 0 during emission.
// ----------------------------------------------------------------------------
module inssort_dp
    import inssort_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    output t_dp_stat              o_stat,
    output t_result               o_result
);

    logic [DATA_WIDTH-1:0] r_held [MAX_ITEMS];
    logic [DATA_WIDTH-1:0] n_held [MAX_ITEMS];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_dropped;
    logic                  n_dropped;
    logic [MAX_ITEMS-1:0]  gt;

    // each cell flags a held value strictly greater than the newcomer
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_held[i] > i_value);
        end
    end

    always_comb begin
        n_held    = r_held;
        n_count   = r_count;
        n_dropped = r_dropped;
        if (i_cmd.insert) begin
            if (r_count < CNT_W'(MAX_ITEMS)) begin
                if (gt[0] || (r_count == '0)) begin
                    n_held[0] = i_value;
                end
                for (int i = 1; i < MAX_ITEMS; i++) begin
                    // take the neighbor below, or land the new value at the boundary
                    if (gt[i-1]) begin
                        n_held[i] = r_held[i-1];
                    end else if (gt[i] || (CNT_W'(i) == r_count)) begin
                        n_held[i] = i_value;
                    end
                end
                n_count = r_count + CNT_W'(1);
            end else begin
                n_dropped = 1'b1;
            end
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_held[i] = r_held[i+1];
            end
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_dropped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    assign o_stat.one_left       = (r_count == CNT_W'(1));
    assign o_result.sorted_value = r_held[0];
    assign o_result.last_result  = (r_count == CNT_W'(1));
    assign o_result.overflow     = r_dropped;

endmodule

[rtl/core/inssort_ctrl.sv]
// ----------------------------------------------------------------------------
// inssort_ctrl
// Controller: loads values while idle, then drains the sorted set.
// ----------------------------------------------------------------------------
module inssort_ctrl
    import inssort_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_final,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_strobe
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        n_state         = r_state;
        o_cmd.insert    = 1'b0;
        o_cmd.shift_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.insert = i_start;
                if (i_start && i_final) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.shift_out = 1'b1;
                if (i_stat.one_left) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state == S_EMIT);
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_busy;

endmodule

[rtl/core/insertion_sorter_top.sv]
// A non-final transaction is inserted into the held set; one new value enters per cycle while busy is low.
// A final transaction is inserted, then all held values (up to MAX_ITEMS) stream out, one result
// per cycle; busy stays high while they stream out.
// The compare-and-shift cell chain sets the insert rate; the shift-out of the chain the drain.
// Reset (synchronous, active low) empties the set and clears the overflow flag.
// ----------------------------------------------------------------------------
// insertion_sorter_top
// Stable ascending insertion sorter with overflow reporting.
// ----------------------------------------------------------------------------
`include "insertion_sorter_top_defines.svh"

module insertion_sorter_top
    import inssort_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_in_item i_in,
    output logic     busy,
    output logic     o_strobe,
    output t_result  o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    inssort_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_final  (i_in.final_item),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    inssort_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_in.value),
        .o_stat   (stat),
        .o_result (o_result)
    );

    `INSSORT_ASSERT(a_final_starts_run, start && !busy && i_in.final_item |=> o_strobe, "final transaction did not start output")
    `INSSORT_ASSERT(a_run_unbroken, o_strobe && !o_result.last_result |=> o_strobe, "output run broke before last result")
    `INSSORT_ASSERT(a_free_after_last, o_strobe && o_result.last_result |=> !busy, "block still busy after last result")
    `INSSORT_ASSERT_ALWAYS(a_no_insert_while_draining, !(cmd.insert && cmd.shift_out), "insert and shift-out together")

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: insertion_sorter_top
// Feeds sets of unsigned values and checks that every emitted set matches a
// stable ascending sort, with end-of-set marking and overflow flagging.
// Single-item, full and over-capacity sets are covered, along with random sets
// sent with random gaps.
// ----------------------------------------------------------------------------
module testbench;
    import inssort_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_in_item i_in;
    logic     busy;
    logic     o_strobe;
    t_result  o_result;

    insertion_sorter_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // sorted store of the predictor and the results still owed by the block
    logic [DATA_WIDTH-1:0] sorted_set[$];
    bit                    set_dropped;
    t_result               owed_results[$];

    int  error_count;
    int  items_sent;
    int  sets_emitted;
    int  overflow_sets;
    int  results_seen;
    bit  gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("insertion_sorter_top: mismatch");
        $finish;
    end

    // insert one accepted value; on the flagged item, emit the whole set
    function automatic void sort_and_emit(t_in_item item);
        int      pos;
        int      n;
        t_result r;
        if (sorted_set.size() < MAX_ITEMS) begin
            pos = sorted_set.size();
            // stop at an equal value so arrival order is kept
            while (pos > 0 && sorted_set[pos-1] > item.value)
                pos--;
            sorted_set.insert(pos, item.value);
        end else begin
            set_dropped = 1'b1;
        end
        if (item.final_item) begin
            n = sorted_set.size();
            for (int k = 0; k < n; k++) begin
                r.sorted_value = sorted_set[k];
                r.last_result  = (k == n - 1);
                r.overflow     = set_dropped;
                owed_results.push_back(r);
            end
            sets_emitted++;
            if (set_dropped)
                overflow_sets++;
            sorted_set.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 7);
            1: v = $urandom_range(0, 1) ? '1 : '0;
            2: v = '1 - $urandom_range(0, 7);
            3: v = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_WIDTH - 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // drop start and put random noise on the payload while idling
    task automatic idle_for(input int n);
        t_in_item noise;
        repeat (n) begin
            @(negedge i_clk);
            noise.value      = $urandom;
            noise.final_item = 1'($urandom_range(0, 1));
            start <= 1'b0;
            i_in  <= noise;
        end
    endtask

    task automatic send_item(input logic [DATA_WIDTH-1:0] v, input bit fin);
        t_in_item item;
        item.value      = v;
        item.final_item = fin;
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= item;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        sort_and_emit(item);
        items_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 3));
    endtask

    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    // hold the sender until every owed result has come out
    task automatic wait_drained();
        idle_for(1);
        while (owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && $isunknown(o_strobe)) begin
            $error("o_strobe is unknown");
            error_count++;
        end else if (i_rst_n && o_strobe) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("unexpected result: sorted_value %0h", o_result.sorted_value);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_result.sorted_value !== want.sorted_value) begin
                    $error("sorted_value: expected %0h, got %0h",
                           want.sorted_value, o_result.sorted_value);
                    error_count++;
                end
                if (o_result.last_result !== want.last_result) begin
                    $error("last_result: expected %0b, got %0b",
                           want.last_result, o_result.last_result);
                    error_count++;
                end
                if (o_result.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, o_result.overflow);
                    error_count++;
                end
            end
        end
    end

    // lone items, extremes, duplicates, reversed order and bit patterns
    task automatic test_directed();
        gaps_on = 1'b0;
        send_item('0, 1'b1);
        send_item('1, 1'b1);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b1);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b1);
        for (int i = 7; i >= 1; i--)
            send_item(i, i == 1);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b1);
    endtask

    // exactly full, then over capacity with the flagged item dropped,
    // then over capacity by several, then a lone item to see the flag clear
    task automatic test_capacity();
        gaps_on = 1'b1;
        send_random_set(MAX_ITEMS);
        send_random_set(MAX_ITEMS + 1);
        wait_drained();
        send_random_set(MAX_ITEMS + 6);
        send_item(pick_value(), 1'b1);
    endtask

    task automatic test_drain_pause();
        gaps_on = 1'b1;
        send_random_set(4);
        wait_drained();
        send_random_set(3);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int len;
        while (items_sent < 420) begin
            case ($urandom_range(0, 15))
                0:       len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 4);
                1, 2:    len = $urandom_range(9, MAX_ITEMS - 1);
                default: len = $urandom_range(1, 8);
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_set(len);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    // back-to-back sets with no gaps at all
    task automatic test_no_idle();
        gaps_on = 1'b0;
        while (items_sent < 470)
            send_random_set($urandom_range(1, 10));
    endtask

    initial begin
        error_count   = 0;
        items_sent    = 0;
        sets_emitted  = 0;
        overflow_sets = 0;
        results_seen  = 0;
        gaps_on       = 1'b0;
        set_dropped   = 1'b0;
        start         = 1'b0;
        i_in          = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_drain_pause();
        test_random_sets();
        test_no_idle();

        wait_drained();
        repeat (MAX_ITEMS + 8) @(posedge i_clk);
        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            error_count++;
        end

        $display("Sent %0d values in %0d sets, %0d of them over capacity.",
                 items_sent, sets_emitted, overflow_sets);
        $display("Checked %0d sorted results, %0d errors.", results_seen, error_count);
        if (error_count == 0)
            $display("insertion_sorter_top: match");
        else
            $display("insertion_sorter_top: mismatch");
        $finish;
    end

endmodule

[insertion_sorter_top.f]
+incdir+rtl/core
rtl/core/inssort_pkg.sv
rtl/core/inssort_dp.sv
rtl/core/inssort_ctrl.sv
rtl/core/insertion_sorter_top.sv
tb/sv/testbench.sv
